@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the counter allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held
`define PCA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define PCA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/pca_pkg.sv @@
// ----------------------------------------------------------------------------
// pca_pkg
// Types, codes and the event offset table of the partition counter allocator.
// ----------------------------------------------------------------------------
package pca_pkg;

    localparam int PARTITIONS  = 256;
    localparam int COUNTERS    = 8;
    localparam int PART_W      = $clog2(PARTITIONS);
    localparam int CNT_W       = $clog2(COUNTERS);
    localparam int EVENT_COUNT = 27;
    localparam int MASK_W      = 27;
    localparam int OFFS_W      = 14;
    localparam int REF_W       = 16;
    localparam int SLOT_SHIFT  = 5;

    localparam logic [MASK_W-1:0] MASK_RESET = 27'h01FFC24;
    localparam logic [REF_W-1:0]  REF_MAX    = 16'hFFFF;

    typedef logic [1:0]          t_op;
    typedef logic [4:0]          t_event;
    typedef logic [7:0]          t_part_id;
    typedef logic [2:0]          t_status;
    typedef logic [2:0]          t_slot;
    typedef logic [OFFS_W-1:0]   t_offset;
    typedef logic [MASK_W-1:0]   t_mask;
    typedef logic [REF_W-1:0]    t_refcnt;

    // Operation codes
    localparam t_op OP_ALLOC  = 2'd0;
    localparam t_op OP_FREE   = 2'd1;
    localparam t_op OP_LOCATE = 2'd2;

    // Status codes
    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_NO_FREE    = 3'd1;
    localparam t_status ST_UNFILTERED = 3'd2;
    localparam t_status ST_INVALID    = 3'd3;
    localparam t_status ST_UNMAPPED   = 3'd4;

    // Register base offset of each event
    function automatic t_offset base_offset(input t_event ev);
        t_offset offs;
        case (ev)
            5'd0:    offs = 14'h0000;
            5'd1:    offs = 14'h0008;
            5'd2:    offs = 14'h0010;
            5'd3:    offs = 14'h0100;
            5'd4:    offs = 14'h0108;
            5'd5:    offs = 14'h0110;
            5'd6:    offs = 14'h0200;
            5'd7:    offs = 14'h0300;
            5'd8:    offs = 14'h0400;
            5'd9:    offs = 14'h0408;
            5'd10:   offs = 14'h0500;
            5'd11:   offs = 14'h0508;
            5'd12:   offs = 14'h0510;
            5'd13:   offs = 14'h0600;
            5'd14:   offs = 14'h0608;
            5'd15:   offs = 14'h0610;
            5'd16:   offs = 14'h0700;
            5'd17:   offs = 14'h0800;
            5'd18:   offs = 14'h0900;
            5'd19:   offs = 14'h0908;
            5'd20:   offs = 14'h0910;
            5'd21:   offs = 14'h2D18;
            5'd22:   offs = 14'h2D20;
            5'd23:   offs = 14'h2D28;
            5'd24:   offs = 14'h2D30;
            5'd25:   offs = 14'h2D38;
            5'd26:   offs = 14'h2D40;
            default: offs = 14'h0000;
        endcase
        return offs;
    endfunction

endpackage

@@ rtl/core/pca_if.sv @@
// ----------------------------------------------------------------------------
// pca_if
// Request and response channels of the partition counter allocator.
// ----------------------------------------------------------------------------
interface pca_req_if import pca_pkg::*; ();
    logic     valid;
    logic     ready;
    t_op      op;
    t_event   event_id;
    t_part_id partition_id;

    modport source (output valid, output op, output event_id, output partition_id,
                    input ready);
    modport sink   (input valid, input op, input event_id, input partition_id,
                    output ready);
endinterface

interface pca_rsp_if import pca_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    t_slot   counter_index;
    t_offset register_offset;

    modport source (output valid, output status, output counter_index,
                    output register_offset, input ready);
    modport sink   (input valid, input status, input counter_index,
                    input register_offset, output ready);
endinterface

@@ rtl/core/partition_counter_allocator_top.sv @@
// ----------------------------------------------------------------------------
// partition_counter_allocator_top
// Reference-counted allocation of filtered counters to traffic partitions.
// ----------------------------------------------------------------------------
// A request is accepted in S_IDLE, where the partition map RAM is read; S_EXEC
// then decides the result, writes the map entry back and loads the response
// register. The response register lets the next request be accepted while
// a result still waits; the decide state stalls only if that register is full.
// The map has per-entry valid bits cleared at reset, so no clearing pass is
// needed. Write the filter mask only while the block is idle.
module partition_counter_allocator_top import pca_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  t_mask         i_cfg_wdata,
    pca_req_if.sink       i_req,
    pca_rsp_if.source     o_rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                 r_state;
    t_mask                r_mask;

    // Request hold
    t_op                  r_op;
    t_event               r_ev;
    logic [PART_W-1:0]    r_part;

    // Partition map RAM and its valid bits
    t_slot                r_map_mem [PARTITIONS];
    logic [PARTITIONS-1:0] r_map_vld;
    t_slot                r_map_q;
    logic                 r_map_q_vld;

    logic [COUNTERS-1:0]  r_busy;
    logic [COUNTERS-1:0]  n_busy;
    t_refcnt              r_refcnt [COUNTERS];
    t_refcnt              n_refcnt [COUNTERS];

    // Response register
    logic                 r_out_valid;
    t_status              r_out_status;
    t_slot                r_out_slot;
    t_offset              r_out_offs;

    logic                 in_acc;
    logic                 exec_done;
    logic                 ev_ok;
    logic                 filtered;
    logic [31:0]          mask_ext;
    t_offset              base;
    t_slot                slot;
    t_refcnt              cur_cnt;
    logic                 free_found;
    t_slot                free_slot;
    logic                 map_we;
    t_slot                map_wdata;
    t_status              n_status;
    t_slot                n_slot;
    t_offset              n_offs;

    assign i_req.ready     = (r_state == S_IDLE);
    assign in_acc          = i_req.valid && i_req.ready;
    assign exec_done       = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.counter_index   = r_out_slot;
    assign o_rsp.register_offset = r_out_offs;

    // Decode the held request against the map entry read when it was accepted
    assign ev_ok    = (r_op <= OP_LOCATE) && (r_ev < 5'(EVENT_COUNT));
    assign mask_ext = 32'(r_mask);
    assign filtered = mask_ext[r_ev];
    assign base     = base_offset(r_ev);
    assign slot     = r_map_q_vld ? r_map_q : '0;
    assign cur_cnt  = r_refcnt[slot];

    // Find the lowest free counter from 1 upward
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int c = COUNTERS - 1; c >= 1; c--) begin
            if (!r_busy[c]) begin
                free_found = 1'b1;
                free_slot  = CNT_W'(c);
            end
        end
    end

    // Decide result and state update
    always_comb begin
        n_busy    = r_busy;
        n_refcnt  = r_refcnt;
        map_we    = 1'b0;
        map_wdata = '0;
        n_status  = ST_OK;
        n_slot    = '0;
        n_offs    = base;
        if (!ev_ok) begin
            n_status = ST_INVALID;
            n_offs   = '0;
        end else if (!filtered) begin
            n_status = ST_UNFILTERED;
        end else begin
            case (r_op)
                OP_ALLOC: begin
                    if (slot != '0) begin
                        if (cur_cnt != REF_MAX) begin
                            n_refcnt[slot] = cur_cnt + 1'b1;
                        end
                        n_slot = slot;
                    end else if (!free_found) begin
                        n_status = ST_NO_FREE;
                    end else begin
                        n_busy[free_slot]   = 1'b1;
                        n_refcnt[free_slot] = REF_W'(1);
                        map_we              = 1'b1;
                        map_wdata           = free_slot;
                        n_slot              = free_slot;
                    end
                end
                OP_FREE: begin
                    if (slot == '0) begin
                        n_status = ST_UNMAPPED;
                    end else begin
                        if (cur_cnt <= REF_W'(1)) begin
                            n_refcnt[slot] = '0;
                            n_busy[slot]   = 1'b0;
                            map_we         = 1'b1;
                            map_wdata      = '0;
                        end else begin
                            n_refcnt[slot] = cur_cnt - 1'b1;
                        end
                        n_slot = slot;
                    end
                end
                default: begin
                    n_status = (slot == '0) ? ST_UNMAPPED : ST_OK;
                    n_slot   = slot;
                end
            endcase
            n_offs = base + (OFFS_W'(n_slot) << SLOT_SHIFT);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= MASK_RESET;
            r_busy      <= COUNTERS'(1);
            r_map_vld   <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < COUNTERS; c++) begin
                r_refcnt[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (exec_done) begin
                r_busy   <= n_busy;
                r_refcnt <= n_refcnt;
                if (map_we) begin
                    r_map_vld[r_part] <= 1'b1;
                end
            end
            // Drop the response once taken, load a new one on completion
            if (exec_done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and map read
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op        <= i_req.op;
            r_ev        <= i_req.event_id;
            r_part      <= i_req.partition_id[PART_W-1:0];
            r_map_q     <= r_map_mem[i_req.partition_id[PART_W-1:0]];
            r_map_q_vld <= r_map_vld[i_req.partition_id[PART_W-1:0]];
        end
    end

    // Map write-back
    always_ff @(posedge i_clk) begin
        if (exec_done && map_we) begin
            r_map_mem[r_part] <= map_wdata;
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if (exec_done) begin
            r_out_status <= n_status;
            r_out_slot   <= n_slot;
            r_out_offs   <= n_offs;
        end
    end

endmodule

@@ rtl/core/pca_checker.sv @@
// ----------------------------------------------------------------------------
// pca_props
// Port-level checks of the partition counter allocator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pca_props import pca_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_status i_status,
    input t_slot   i_counter_index,
    input t_offset i_register_offset
);

    // Hold a stalled response
    `PCA_ASSERT(a_out_hold,
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)
            && $stable(i_counter_index) && $stable(i_register_offset)),
        "stalled response changed")

    // Refuse a request in the cycle after a transaction is accepted
    `PCA_ASSERT(a_one_at_a_time, (i_in_valid && i_in_ready) |=> !i_in_ready,
        "request accepted during map update")

    // Tie counter slot to status
    `PCA_ASSERT(a_slot_status,
        i_out_valid |-> ((i_status == ST_OK) == (i_counter_index != '0)),
        "counter slot disagrees with status")

    // Zero offset on an invalid event
    `PCA_ASSERT(a_invalid_offs,
        (i_out_valid && (i_status == ST_INVALID)) |-> (i_register_offset == '0),
        "invalid event returned an offset")

    // Clear the response after reset
    `PCA_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !i_out_valid, "response valid after reset")

endmodule

bind partition_counter_allocator_top pca_props u_pca_props (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_req.valid),
    .i_in_ready        (i_req.ready),
    .i_out_valid       (o_rsp.valid),
    .i_out_ready       (o_rsp.ready),
    .i_status          (o_rsp.status),
    .i_counter_index   (o_rsp.counter_index),
    .i_register_offset (o_rsp.register_offset)
);
